>>> rtl/core/unv_pkg.sv
package unv_pkg;

  // Default counter width of the byte offsets
  localparam int OFFSET_BITS = 13;

  // Fixed field widths
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;
  localparam int CFG_W    = 13;
  localparam int SCALAR_W = 21;

  // Configuration register indexes
  localparam logic CFG_MAX_INPUT   = 1'b0;
  localparam logic CFG_MAX_TRIMMED = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] MAX_INPUT_RST   = 13'd4096;
  localparam logic [CFG_W-1:0] MAX_TRIMMED_RST = 13'd128;

  // Verdict codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_BAD_UTF8    = 3'd2,
    ST_BLANK       = 3'd3,
    ST_CONTROL     = 3'd4,
    ST_TRIM_LONG   = 3'd5
  } status_e;

  // Sticky error level, only ever raised
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CTRL = 2'd1,
    ERR_UTF8 = 2'd2,
    ERR_LONG = 2'd3
  } err_e;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_item;
    logic              empty_marker;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [START_W-1:0] start_offset;
    logic [LEN_W-1:0]   trimmed_length;
  } result_t;

  // Unicode whitespace
  function automatic logic is_space(input logic [SCALAR_W-1:0] c);
    is_space = (c >= 21'h9 && c <= 21'hD) || c == 21'h20 || c == 21'h85 ||
               c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202F || c == 21'h205F ||
               c == 21'h3000;
  endfunction

  // Control and format characters (Cc, Cf)
  function automatic logic is_ctrl(input logic [SCALAR_W-1:0] c);
    is_ctrl = c < 21'h20 || (c >= 21'h7F && c <= 21'h9F) || c == 21'hAD ||
              (c >= 21'h600 && c <= 21'h605) || c == 21'h61C || c == 21'h6DD ||
              c == 21'h70F || (c >= 21'h890 && c <= 21'h891) || c == 21'h8E2 ||
              c == 21'h180E || (c >= 21'h200B && c <= 21'h200F) ||
              (c >= 21'h202A && c <= 21'h202E) || (c >= 21'h2060 && c <= 21'h2064) ||
              (c >= 21'h2066 && c <= 21'h206F) || c == 21'hFEFF ||
              (c >= 21'hFFF9 && c <= 21'hFFFB) || c == 21'h110BD || c == 21'h110CD ||
              (c >= 21'h13430 && c <= 21'h1343F) || (c >= 21'h1BCA0 && c <= 21'h1BCA3) ||
              (c >= 21'h1D173 && c <= 21'h1D17A) || c == 21'hE0001 ||
              (c >= 21'hE0020 && c <= 21'hE007F);
  endfunction

endpackage

>>> rtl/core/unv_in_if.sv
interface unv_in_if;
  import unv_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_item;
  logic              empty_marker;

  modport source (output valid, data_byte, last_item, empty_marker, input ready);
  modport sink   (input valid, data_byte, last_item, empty_marker, output ready);
endinterface

>>> rtl/core/unv_out_if.sv
interface unv_out_if;
  import unv_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_offset;
  logic [LEN_W-1:0]    trimmed_length;

  modport source (output valid, status, start_offset, trimmed_length, input ready);
  modport sink   (input valid, status, start_offset, trimmed_length, output ready);
endinterface

>>> rtl/core/unv_in_reg.sv
module unv_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  unv_in_if.sink             in_i,
  input  logic               take_i,
  output logic               valid_o,
  output unv_pkg::in_item_t  item_o
);
  import unv_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  logic     load;

  // Slot frees when the core consumes the held byte
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte    <= in_i.data_byte;
      item_q.last_item    <= in_i.last_item;
      item_q.empty_marker <= in_i.empty_marker;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

>>> rtl/core/unv_core.sv
module unv_core #(
  parameter int OffsetBits = unv_pkg::OFFSET_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  input  unv_pkg::in_item_t          item_i,
  input  logic                       slot_free_i,
  input  logic [unv_pkg::CFG_W-1:0]  max_input_i,
  input  logic [unv_pkg::CFG_W-1:0]  max_trimmed_i,
  output logic                       take_o,
  output logic                       res_valid_o,
  output unv_pkg::result_t           res_o
);
  import unv_pkg::*;

  localparam int CmpW = (OffsetBits + 1 > CFG_W) ? OffsetBits + 1 : CFG_W;
  localparam logic [OffsetBits-1:0] CntMax = {OffsetBits{1'b1}};

  // Running state of the current string
  logic [OffsetBits-1:0] cnt_q, cnt_d;
  logic [1:0]            pend_q, pend_d;
  logic [SCALAR_W-1:0]   acc_q, acc_d;
  logic [1:0]            cls_q, cls_d;
  logic [OffsetBits-1:0] sbeg_q, sbeg_d;
  logic                  seen_q, seen_d;
  logic [OffsetBits-1:0] span_beg_q, span_beg_d;
  logic [OffsetBits-1:0] span_end_q, span_end_d;
  logic                  psc_q, psc_d;
  err_e                  err_q, err_d;

  logic                  fin;
  logic                  fire;
  logic                  at_max;
  logic                  too_long;
  logic [OffsetBits-1:0] after;
  logic [DATA_W-1:0]     b;
  logic [SCALAR_W-1:0]   acc_n;
  logic                  scal_vld;
  logic [SCALAR_W-1:0]   scal;
  logic [OffsetBits-1:0] scal_beg;
  logic                  bad_value;
  err_e                  err_fin;
  logic [OffsetBits-1:0] span_len;
  logic [CmpW-1:0]       start_ext;
  logic [CmpW-1:0]       len_ext;
  result_t               res;

  assign fin    = item_i.empty_marker || item_i.last_item;
  assign fire   = item_valid_i && (!fin || slot_free_i);
  assign b      = item_i.data_byte;
  assign at_max = (cnt_q == CntMax);
  assign too_long = at_max || (CmpW'(cnt_q) + CmpW'(1) > CmpW'(max_input_i));
  assign after  = at_max ? cnt_q : cnt_q + OffsetBits'(1);
  assign acc_n  = {acc_q[SCALAR_W-7:0], b[5:0]};

  // Completed multi-byte scalar: overlong, above range or surrogate
  always_comb begin
    bad_value = (acc_n > 21'h10FFFF) || (acc_n >= 21'hD800 && acc_n <= 21'hDFFF);
    case (cls_q)
      2'd1:    bad_value = bad_value || (acc_n < 21'h80);
      2'd2:    bad_value = bad_value || (acc_n < 21'h800);
      default: bad_value = bad_value || (acc_n < 21'h10000);
    endcase
  end

  // Byte decode and trim tracking
  always_comb begin
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    cls_d      = cls_q;
    sbeg_d     = sbeg_q;
    seen_d     = seen_q;
    span_beg_d = span_beg_q;
    span_end_d = span_end_q;
    psc_d      = psc_q;
    err_d      = err_q;
    scal_vld   = 1'b0;
    scal       = acc_n;
    scal_beg   = sbeg_q;

    if (!item_i.empty_marker) begin
      cnt_d = after;
      if (too_long) begin
        err_d = ERR_LONG;
      end
      if (err_d < ERR_UTF8) begin
        if (pend_q == 2'd0) begin
          sbeg_d = cnt_q;
          if (b < 8'h80) begin
            scal_vld = 1'b1;
            scal     = SCALAR_W'(b);
            scal_beg = cnt_q;
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            acc_d  = SCALAR_W'(b[4:0]);
            pend_d = 2'd1;
            cls_d  = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            acc_d  = SCALAR_W'(b[3:0]);
            pend_d = 2'd2;
            cls_d  = 2'd2;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            acc_d  = SCALAR_W'(b[2:0]);
            pend_d = 2'd3;
            cls_d  = 2'd3;
          end else begin
            err_d = ERR_UTF8;
          end
        end else if (b[7:6] != 2'b10) begin
          err_d = ERR_UTF8;
        end else begin
          acc_d  = acc_n;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            if (bad_value) begin
              err_d = ERR_UTF8;
            end else begin
              scal_vld = 1'b1;
            end
          end
        end
      end
    end

    // Whitespace leaves the span alone (control-class whitespace after text is noted), content extends the span
    if (scal_vld) begin
      if (is_space(scal)) begin
        if (seen_q && is_ctrl(scal)) begin
          psc_d = 1'b1;
        end
      end else begin
        if (((seen_q && psc_q) || is_ctrl(scal)) && err_d == ERR_NONE) begin
          err_d = ERR_CTRL;
        end
        if (!seen_q) begin
          span_beg_d = scal_beg;
        end
        seen_d     = 1'b1;
        psc_d      = 1'b0;
        span_end_d = after;
      end
    end
  end

  // Verdict on the ending transaction
  always_comb begin
    err_fin = err_d;
    if (err_d < ERR_UTF8 && pend_d != 2'd0) begin
      err_fin = ERR_UTF8;
    end
    span_len  = span_end_d - span_beg_d;
    start_ext = CmpW'(span_beg_d);
    len_ext   = CmpW'(span_len);
    res.start_offset   = '0;
    res.trimmed_length = '0;
    if (err_fin == ERR_LONG) begin
      res.status = ST_TOO_LONG;
    end else if (err_fin == ERR_UTF8) begin
      res.status = ST_BAD_UTF8;
    end else if (!seen_d) begin
      res.status = ST_BLANK;
    end else if (err_fin == ERR_CTRL) begin
      res.status = ST_CONTROL;
    end else if (len_ext > CmpW'(max_trimmed_i)) begin
      res.status = ST_TRIM_LONG;
    end else begin
      res.status         = ST_OK;
      res.start_offset   = start_ext[START_W-1:0];
      res.trimmed_length = len_ext[LEN_W-1:0];
    end
  end

  // State registers, cleared after each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pend_q     <= '0;
      acc_q      <= '0;
      cls_q      <= '0;
      sbeg_q     <= '0;
      seen_q     <= 1'b0;
      span_beg_q <= '0;
      span_end_q <= '0;
      psc_q      <= 1'b0;
      err_q      <= ERR_NONE;
    end else if (fire && fin) begin
      cnt_q      <= '0;
      pend_q     <= '0;
      acc_q      <= '0;
      cls_q      <= '0;
      sbeg_q     <= '0;
      seen_q     <= 1'b0;
      span_beg_q <= '0;
      span_end_q <= '0;
      psc_q      <= 1'b0;
      err_q      <= ERR_NONE;
    end else if (fire) begin
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      acc_q      <= acc_d;
      cls_q      <= cls_d;
      sbeg_q     <= sbeg_d;
      seen_q     <= seen_d;
      span_beg_q <= span_beg_d;
      span_end_q <= span_end_d;
      psc_q      <= psc_d;
      err_q      <= err_d;
    end
  end

  assign take_o      = fire;
  assign res_valid_o = fire && fin;
  assign res_o       = res;

  // Checks
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && fin |=> cnt_q == '0 && !seen_q && err_q == ERR_NONE && pend_q == 2'd0)
    else $error("state not cleared after ending transaction");

  a_pend_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd0 |-> cls_q != 2'd0 && pend_q <= cls_q)
    else $error("pending continuations exceed sequence class");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> span_end_q >= span_beg_q && span_end_q <= cnt_q)
    else $error("trimmed span out of order");

  a_result_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> slot_free_i && item_valid_i)
    else $error("result produced without a free output slot");
endmodule

>>> rtl/core/unv_out_reg.sv
module unv_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  unv_pkg::result_t  res_i,
  output logic              slot_free_o,
  unv_out_if.source         out_o
);
  import unv_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Slot is free when empty or the held result leaves this cycle
  assign slot_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.start_offset   = res_q.start_offset;
  assign out_o.trimmed_length = res_q.trimmed_length;
endmodule

>>> rtl/core/utf8_name_validator_trimmer.sv
// UTF-8 name validator and trimmer.
//
// in_i carries one byte of a name per transaction, with last_item on the
// final byte; an empty name is a single transaction with empty_marker set.
// out_o carries one verdict per name: status, plus start offset and trimmed
// byte length when status is ok (both zero otherwise).
// Configuration: cfg_we_i writes cfg_data_i into max_input_bytes (index 0)
// or max_trimmed_bytes (index 1); write only while the block is idle.
//
// Throughput: one byte per cycle unless an ending byte waits on a full output
// register. Each byte is held in an input register, decoded combinationally
// against the running string state, and the verdict is written to an output
// register, so an ending transaction passes through both registers to out_o.
// A stalled receiver holds the verdict in the output register; non-ending
// bytes keep flowing, and an ending byte waits in the input register until
// the output register frees.
// Reset clears all string state and loads max_input_bytes = 4096 and
// max_trimmed_bytes = 128; no clearing pass is needed.
module utf8_name_validator_trimmer #(
  parameter int OffsetBits = unv_pkg::OFFSET_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  unv_in_if.sink                    in_i,
  unv_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [unv_pkg::CFG_W-1:0] cfg_data_i
);
  import unv_pkg::*;

  logic [CFG_W-1:0] max_input_q;
  logic [CFG_W-1:0] max_trimmed_q;
  logic             item_valid;
  in_item_t         item;
  logic             take;
  logic             slot_free;
  logic             res_valid;
  result_t          res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_input_q   <= MAX_INPUT_RST;
      max_trimmed_q <= MAX_TRIMMED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_INPUT:   max_input_q   <= cfg_data_i;
        CFG_MAX_TRIMMED: max_trimmed_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  unv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  unv_core #(
    .OffsetBits (OffsetBits)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .slot_free_i   (slot_free),
    .max_input_i   (max_input_q),
    .max_trimmed_i (max_trimmed_q),
    .take_o        (take),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  unv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );
endmodule

>>> tb/sv/utf8_name_validator_trimmer_tb.sv
`timescale 1ns / 1ps

module utf8_name_validator_trimmer_tb;
  import unv_pkg::*;

  localparam int          DIR_N       = 25;
  localparam int          PHASE_ITEMS = 190;
  localparam int          LONG_HOLD   = 60;
  localparam int          WDOG_LIMIT  = 2000;
  localparam int unsigned POS_TOP     = (1 << OFFSET_BITS) - 1;

  typedef struct packed {
    in_item_t item;
    logic     typed;
    result_t  want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  unv_in_if  name_bus ();
  unv_out_if verdict_bus ();

  utf8_name_validator_trimmer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (name_bus),
    .out_o      (verdict_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Verdicts still owed by the block, oldest first
  result_t     verdict_q[$];
  logic [7:0]  name_q[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          src_stall_pct = 0;
  int          snk_stall_pct = 0;
  bit          hold_sink = 1'b0;
  dir_row_t    dir_tab [DIR_N];

  // Shadow of the decoder state and limits
  logic [CFG_W-1:0] lim_in, lim_trim;
  logic [12:0]      byte_pos, code_start, text_start, text_stop;
  logic [1:0]       cont_left, code_form;
  logic [20:0]      code_acc;
  logic             got_text, ws_ctrl_tail;
  err_e             err_lvl;

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit between(input logic [20:0] c, input logic [20:0] lo,
                                 input logic [20:0] hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic bit ws_scalar(input logic [20:0] c);
    case (c)
      21'h20, 21'h85, 21'hA0, 21'h1680, 21'h2028, 21'h2029, 21'h202F, 21'h205F,
      21'h3000: return 1'b1;
      default:  return between(c, 21'h9, 21'hD) || between(c, 21'h2000, 21'h200A);
    endcase
  endfunction

  // Cc and Cf
  function automatic bit ctrl_scalar(input logic [20:0] c);
    case (c)
      21'hAD, 21'h61C, 21'h6DD, 21'h70F, 21'h890, 21'h891, 21'h8E2, 21'h180E,
      21'hFEFF, 21'h110BD, 21'h110CD, 21'hE0001: return 1'b1;
      default: return c <= 21'h1F || between(c, 21'h7F, 21'h9F) ||
                      between(c, 21'h600, 21'h605) || between(c, 21'h200B, 21'h200F) ||
                      between(c, 21'h202A, 21'h202E) || between(c, 21'h2060, 21'h2064) ||
                      between(c, 21'h2066, 21'h206F) || between(c, 21'hFFF9, 21'hFFFB) ||
                      between(c, 21'h13430, 21'h1343F) ||
                      between(c, 21'h1BCA0, 21'h1BCA3) ||
                      between(c, 21'h1D173, 21'h1D17A) ||
                      between(c, 21'hE0020, 21'hE007F);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  task automatic clear_string();
    byte_pos = '0; cont_left = '0; code_acc = '0; code_form = '0; code_start = '0;
    got_text = 1'b0; text_start = '0; text_stop = '0; ws_ctrl_tail = 1'b0;
    err_lvl = ERR_NONE;
  endtask

  task automatic bump_err(input err_e lvl);
    if (lvl > err_lvl) err_lvl = lvl;
  endtask

  // One whole scalar covering bytes [b, e)
  task automatic note_scalar(input logic [20:0] c, input logic [12:0] b,
                             input logic [12:0] e);
    if (ws_scalar(c)) begin
      // control-class whitespace after text poisons any later text
      if (got_text && ctrl_scalar(c)) ws_ctrl_tail = 1'b1;
    end else begin
      if ((got_text && ws_ctrl_tail) || ctrl_scalar(c)) bump_err(ERR_CTRL);
      if (!got_text) text_start = b;
      got_text = 1'b1;
      ws_ctrl_tail = 1'b0;
      text_stop = e;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [12:0] here;
    logic [20:0] floor_v;
    here = byte_pos;
    if (int'(byte_pos) == POS_TOP || int'(byte_pos) + 1 > int'(lim_in)) bump_err(ERR_LONG);
    if (int'(byte_pos) < POS_TOP) byte_pos = byte_pos + 13'd1;
    // after bad UTF-8 bytes are only counted
    if (err_lvl >= ERR_UTF8) return;
    if (cont_left == 2'd0) begin
      code_start = here;
      if (b < 8'h80) begin
        note_scalar({13'd0, b}, here, byte_pos);
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        code_acc = {16'd0, b[4:0]}; cont_left = 2'd1; code_form = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        code_acc = {17'd0, b[3:0]}; cont_left = 2'd2; code_form = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        code_acc = {18'd0, b[2:0]}; cont_left = 2'd3; code_form = 2'd3;
      end else begin
        bump_err(ERR_UTF8);
      end
    end else if (b[7:6] != 2'b10) begin
      bump_err(ERR_UTF8);
    end else begin
      code_acc = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        floor_v = (code_form == 2'd1) ? 21'h80 : (code_form == 2'd2) ? 21'h800 : 21'h10000;
        // overlong, above the code space, or surrogate
        if (code_acc < floor_v || code_acc > 21'h10FFFF || between(code_acc, 21'hD800, 21'hDFFF))
          bump_err(ERR_UTF8);
        else
          note_scalar(code_acc, code_start, byte_pos);
      end
    end
  endtask

  task automatic predict_item(input in_item_t it, output bit fin, output result_t v);
    logic [12:0] span;
    fin = 1'b0;
    v = '0;
    if (!it.empty_marker) decode_byte(it.data_byte);
    if (!it.empty_marker && !it.last_item) return;
    fin = 1'b1;
    // truncated sequence at the end of the string
    if (err_lvl < ERR_UTF8 && cont_left != 2'd0) bump_err(ERR_UTF8);
    span = text_stop - text_start;
    if (err_lvl == ERR_LONG) begin
      v.status = ST_TOO_LONG;
    end else if (err_lvl == ERR_UTF8) begin
      v.status = ST_BAD_UTF8;
    end else if (!got_text) begin
      v.status = ST_BLANK;
    end else if (err_lvl == ERR_CTRL) begin
      v.status = ST_CONTROL;
    end else if (span > lim_trim) begin
      v.status = ST_TRIM_LONG;
    end else begin
      v.status = ST_OK;
      v.start_offset = text_start[START_W-1:0];
      v.trimmed_length = span;
    end
    clear_string();
  endtask

  // ---------------------------------------------------------------------------
  // Name transaction driver
  // ---------------------------------------------------------------------------
  task automatic offer(input in_item_t it, input logic typed, input result_t hand);
    bit      fin;
    result_t guess;
    if (src_stall_pct != 0 && $urandom_range(1, 100) <= src_stall_pct) begin
      name_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    name_bus.valid        <= 1'b1;
    name_bus.data_byte    <= it.data_byte;
    name_bus.last_item    <= it.last_item;
    name_bus.empty_marker <= it.empty_marker;
    @(posedge clk_i);
    while (!name_bus.ready) @(posedge clk_i);
    predict_item(it, fin, guess);
    if (fin) verdict_q.insert(verdict_q.size(), typed ? hand : guess);
  endtask

  // Sender pause: wait out every owed verdict plus the pipeline latency
  task automatic settle();
    name_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] in_lim, input logic [CFG_W-1:0] trim_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_INPUT;
    cfg_data_i <= in_lim;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_TRIMMED;
    cfg_data_i <= trim_lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_in   = in_lim;
    lim_trim = trim_lim;
  endtask

  // ---------------------------------------------------------------------------
  // Random names
  // ---------------------------------------------------------------------------
  function automatic logic [20:0] pick_space();
    case ($urandom_range(0, 10))
      0:       return 21'($urandom_range(9, 13));
      1:       return 21'h20;
      2:       return 21'h85;
      3:       return 21'hA0;
      4:       return 21'h1680;
      5:       return 21'($urandom_range(21'h2000, 21'h200A));
      6:       return 21'h2028;
      7:       return 21'h2029;
      8:       return 21'h202F;
      9:       return 21'h205F;
      default: return 21'h3000;
    endcase
  endfunction

  function automatic logic [20:0] pick_ctrl();
    case ($urandom_range(0, 13))
      0:       return 21'($urandom_range(0, 31));
      1:       return 21'($urandom_range(21'h7F, 21'h9F));
      2:       return 21'hAD;
      3:       return 21'($urandom_range(21'h600, 21'h605));
      4:       return 21'h61C;
      5:       return 21'h8E2;
      6:       return 21'($urandom_range(21'h200B, 21'h200F));
      7:       return 21'($urandom_range(21'h202A, 21'h202E));
      8:       return 21'($urandom_range(21'h2060, 21'h206F));
      9:       return 21'hFEFF;
      10:      return 21'($urandom_range(21'hFFF9, 21'hFFFB));
      11:      return 21'($urandom_range(21'h13430, 21'h1343F));
      12:      return 21'($urandom_range(21'h1D173, 21'h1D17A));
      default: return 21'($urandom_range(21'hE0000, 21'hE0080));
    endcase
  endfunction

  function automatic logic [20:0] pick_plain();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 21'($urandom_range(21'h21, 21'h7E));
      4:          return 21'($urandom_range(21'hA1, 21'h7FF));
      5:          return 21'($urandom_range(21'h800, 21'hD7FF));
      6:          return 21'($urandom_range(21'hE000, 21'hFFFF));
      7:          return 21'($urandom_range(21'h10000, 21'h10FFFF));
      8: begin
        // edges of the encoding forms and of the class ranges
        case ($urandom_range(0, 11))
          0:       return 21'h80;
          1:       return 21'h7FF;
          2:       return 21'h800;
          3:       return 21'hD7FF;
          4:       return 21'hE000;
          5:       return 21'hFFFF;
          6:       return 21'h10000;
          7:       return 21'h10FFFF;
          8:       return 21'h110BD;
          9:       return 21'h110CD;
          10:      return 21'h1BCA3;
          default: return 21'h180E;
        endcase
      end
      default:    return 21'($urandom_range(21'h100, 21'h3100));
    endcase
  endfunction

  // Append one byte to the name under construction
  task automatic queue_byte(input logic [7:0] v);
    name_q.insert(name_q.size(), v);
  endtask

  task automatic push_scalar(input logic [20:0] c);
    if (c < 21'h80) begin
      queue_byte(c[7:0]);
    end else if (c < 21'h800) begin
      queue_byte({3'b110, c[10:6]});
      queue_byte({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      queue_byte({4'b1110, c[15:12]});
      queue_byte({2'b10, c[11:6]});
      queue_byte({2'b10, c[5:0]});
    end else begin
      queue_byte({5'b11110, c[20:18]});
      queue_byte({2'b10, c[17:12]});
      queue_byte({2'b10, c[11:6]});
      queue_byte({2'b10, c[5:0]});
    end
  endtask

  task automatic push_cont();
    queue_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Malformed pieces
  task automatic push_bad();
    case ($urandom_range(0, 7))
      0: push_cont();
      1: begin queue_byte(8'($urandom_range(8'hC0, 8'hC1))); push_cont(); end
      2: queue_byte(8'($urandom_range(8'hF5, 8'hFF)));
      3: begin  // overlong 3-byte
        queue_byte(8'hE0);
        queue_byte(8'($urandom_range(8'h80, 8'h9F)));
        push_cont();
      end
      4: begin  // overlong 4-byte
        queue_byte(8'hF0);
        queue_byte(8'($urandom_range(8'h80, 8'h8F)));
        push_cont(); push_cont();
      end
      5: begin  // surrogate
        queue_byte(8'hED);
        queue_byte(8'($urandom_range(8'hA0, 8'hBF)));
        push_cont();
      end
      6: begin  // above 0x10FFFF
        queue_byte(8'hF4);
        queue_byte(8'($urandom_range(8'h90, 8'hBF)));
        push_cont(); push_cont();
      end
      default: queue_byte(8'($urandom_range(8'hC2, 8'hF4)));  // lead only
    endcase
  endtask

  task automatic build_name();
    int mode, lead, n, trail, total, bad_at, p, r;
    name_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    lead  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    trail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 29) == 0)     n = $urandom_range(20, 140);
    else if ($urandom_range(0, 4) == 0) n = 0;
    else                                n = $urandom_range(1, 8);
    total  = lead + n + trail;
    bad_at = (mode < 20) ? $urandom_range(0, total) : -1;
    for (p = 0; p < total; p++) begin
      if (p == bad_at) push_bad();
      if (p < lead || p >= lead + n) begin
        push_scalar(pick_space());
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0)     push_scalar(pick_ctrl());
        else if (r < 3) push_scalar(pick_space());
        else            push_scalar(pick_plain());
      end
    end
    if (bad_at == total) push_bad();
  endtask

  task automatic send_name();
    in_item_t it;
    bit       tail_marker;
    int       i, n;
    n = name_q.size();
    tail_marker = (n == 0) || ($urandom_range(0, 11) == 0);
    for (i = 0; i < n; i++) begin
      it.data_byte    = name_q[i];
      it.last_item    = !tail_marker && (i == n - 1);
      it.empty_marker = 1'b0;
      offer(it, 1'b0, '0);
      items_sent++;
    end
    if (tail_marker) begin
      it.data_byte    = 8'($urandom_range(0, 255));
      it.last_item    = 1'($urandom_range(0, 1));
      it.empty_marker = 1'b1;
      offer(it, 1'b0, '0);
      items_sent++;
    end
  endtask

  task automatic run_names(input int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      build_name();
      send_name();
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int       i, ph;
    in_item_t it;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_MAX_INPUT;
    cfg_data_i            <= '0;
    name_bus.valid        <= 1'b0;
    name_bus.data_byte    <= '0;
    name_bus.last_item    <= 1'b0;
    name_bus.empty_marker <= 1'b0;
    lim_in   = MAX_INPUT_RST;
    lim_trim = MAX_TRIMMED_RST;
    clear_string();

    // Directed names; expected verdict typed in where it is obvious
    dir_tab = '{
      '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_BLANK,   12'd0, 13'd0}},  // empty name
      '{'{8'h41, 1'b1, 1'b0}, 1'b1, '{ST_OK,      12'd0, 13'd1}},
      '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{ST_CONTROL, 12'd0, 13'd0}},
      '{'{8'hE0, 1'b0, 1'b0}, 1'b0, '0},                           // overlong
      '{'{8'h80, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b1, '{ST_BAD_UTF8, 12'd0, 13'd0}},
      '{'{8'hED, 1'b0, 1'b0}, 1'b0, '0},                           // surrogate
      '{'{8'hA0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b1, '{ST_BAD_UTF8, 12'd0, 13'd0}},
      '{'{8'hF4, 1'b0, 1'b0}, 1'b0, '0},                           // 0x110000
      '{'{8'h90, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b1, '{ST_BAD_UTF8, 12'd0, 13'd0}},
      '{'{8'hC3, 1'b1, 1'b0}, 1'b1, '{ST_BAD_UTF8, 12'd0, 13'd0}},  // truncated
      '{'{8'h20, 1'b0, 1'b0}, 1'b0, '0},                           // trimmed 2-byte
      '{'{8'hC3, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hA9, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h20, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b0, 1'b0}, 1'b0, '0},                           // marker after bytes
      '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0},
      '{'{8'h61, 1'b0, 1'b0}, 1'b0, '0},                           // NEL between text
      '{'{8'hC2, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h85, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h09, 1'b1, 1'b0}, 1'b1, '{ST_BLANK,   12'd0, 13'd0}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) offer(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_limits(13'd24, 13'd8);
        2: set_limits(13'd1, 13'd1);
        3: set_limits(13'd4096, 13'd4096);
        4: set_limits(13'd0, 13'd0);
        5: set_limits(13'h1FFF, 13'd40);
        default: ;
      endcase
      if (ph == 5) begin
        // closing stretch runs without random stalls on either side
        src_stall_pct = 0;
        snk_stall_pct = 0;
      end else begin
        src_stall_pct = 15 * $urandom_range(0, 2);
        snk_stall_pct = 15 * $urandom_range(0, 2);
      end
      if (ph == 1) begin
        // receiver stalls long while one-byte names keep coming
        hold_sink = 1'b1;
        repeat (24) begin
          it = '{8'($urandom_range(8'h21, 8'h7E)), 1'b1, 1'b0};
          offer(it, 1'b0, '0);
        end
        settle();
      end
      run_names(PHASE_ITEMS);
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Verdict receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    verdict_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        verdict_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (snk_stall_pct != 0 && $urandom_range(1, 100) <= snk_stall_pct) begin
        verdict_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        verdict_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict check against the oldest owed transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : verdict_check
    result_t want;
    if (rst_ni && verdict_bus.valid && verdict_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no name pending: status %0d", verdict_bus.status);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, verdict_bus.status);
          mismatches++;
        end
        if (verdict_bus.start_offset !== want.start_offset) begin
          $error("start_offset: expected %0d, got %0d", want.start_offset,
                 verdict_bus.start_offset);
          mismatches++;
        end
        if (verdict_bus.trimmed_length !== want.trimmed_length) begin
          $error("trimmed_length: expected %0d, got %0d", want.trimmed_length,
                 verdict_bus.trimmed_length);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((name_bus.valid && name_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
